// ----- hw/rtl/fpd_pkg.sv -----
// Shared constants, types and helpers for the fuzzy PD controller.
// No dependencies; imported by fpd_member, fpd_defuzz and the top level.
`default_nettype none

package fpd_pkg;

    localparam int SETS      = 5;
    localparam int HALF      = (SETS - 1) / 2;
    localparam int RULE_BASE = (3 * (SETS - 1)) / 2;
    localparam int LANES     = 2 * SETS;

    // register indices
    localparam logic [1:0] REG_CENTRE  = 2'd0;
    localparam logic [1:0] REG_WIDTH   = 2'd1;
    localparam logic [1:0] REG_SPACING = 2'd2;
    localparam logic [1:0] REG_SHAPE   = 2'd3;

    // datapath widths
    localparam int CTR_W     = 19;           // set centres, signed
    localparam int AD_W      = 18;           // |x - centre|
    localparam int MU_W      = 17;           // membership, Q0.16 incl. 1.0
    localparam int MU_FRAC   = 16;
    localparam logic [MU_W-1:0] MU_ONE = MU_W'(1) << MU_FRAC;
    localparam int NUM_W     = 39;           // membership dividend
    localparam int DEN_W     = 30;           // membership divisor
    localparam int DIV_STEPS = 17;           // membership quotient bits
    localparam int DIV_W     = NUM_W + 8;    // trial divisor width
    localparam int GEXP_BITS = 8;
    localparam int W_W       = MU_W + $clog2(SETS * SETS);
    localparam int P_W       = W_W + 1 + CTR_W;
    localparam int NM_W      = P_W + $clog2(SETS);
    localparam int M_W       = NM_W + 9;
    localparam int QDIV_STEPS = 23;
    localparam int OUT_W     = 24;
    localparam logic [OUT_W-1:0] OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_OVER = OUT_W'(1) << (OUT_W - 1);

    // pipeline stage map
    localparam int ST_IN    = 0;
    localparam int ST_P1    = 1;
    localparam int ST_P2    = 2;
    localparam int ST_DIV   = 3;
    localparam int ST_POST  = ST_DIV + DIV_STEPS;
    localparam int ST_GMUL  = ST_POST + 1;
    localparam int ST_MIN   = ST_GMUL + GEXP_BITS;
    localparam int ST_AGG   = ST_MIN + 1;
    localparam int ST_PROD  = ST_AGG + 1;
    localparam int ST_SUM   = ST_PROD + 1;
    localparam int ST_PRE   = ST_SUM + 1;
    localparam int ST_QDIV  = ST_PRE + 1;
    localparam int ST_OUT   = ST_QDIV + QDIV_STEPS;
    localparam int NSTG     = ST_OUT + 1;

    // Q0.16 of 2.7132^-(2^(b-4))
    localparam logic [15:0] GEXP [GEXP_BITS] = '{
        16'd61573, 16'd57849, 16'd51063, 16'd39787,
        16'd24155, 16'd8903,  16'd1209,  16'd22
    };

    typedef struct packed {
        logic signed [15:0] centre;
        logic [14:0]        width;
        logic [14:0]        spacing;
        logic               shape_mode;
    } cfg_t;

    function automatic logic signed [CTR_W-1:0] set_ctr(input cfg_t c, input int k);
        logic signed [CTR_W-1:0] base;
        logic signed [CTR_W-1:0] step;
        logic signed [CTR_W-1:0] off;
        base = CTR_W'(c.centre);
        step = signed'(CTR_W'(c.spacing));
        off  = CTR_W'(k - HALF);
        return base + off * step;
    endfunction

    function automatic int rule_out(input int i, input int j);
        int r;
        r = RULE_BASE - i - j;
        if (r < 0)
            r = 0;
        if (r > SETS - 1)
            r = SETS - 1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fpd_member.sv -----
// Membership evaluation for all lanes: triangle or gaussian, pipelined divide
// and exponent product chain. Depends on fpd_pkg; stage enables come from the top.
`default_nettype none

module fpd_member
(
    input  logic                                          clk,
    input  logic [fpd_pkg::NSTG-1:0]                      en,
    input  fpd_pkg::cfg_t                                 cfg,
    input  logic [fpd_pkg::LANES-1:0][fpd_pkg::AD_W-1:0]  ad,
    output logic [fpd_pkg::LANES-1:0][fpd_pkg::MU_W-1:0]  mu
);
    import fpd_pkg::*;

    logic [DEN_W-1:0]   w2_reg;
    logic [2*AD_W-1:0]  sq [LANES];
    logic [NUM_W-1:0]   n1_next [LANES];
    logic [NUM_W-1:0]   n1_reg  [LANES];
    logic               z1_reg  [LANES];

    logic [NUM_W-1:0]   rem_reg [DIV_STEPS+1][LANES];
    logic [DEN_W-1:0]   dv_reg  [DIV_STEPS+1][LANES];
    logic [MU_W-1:0]    q_reg   [DIV_STEPS+1][LANES];
    logic               fc_reg  [DIV_STEPS+1][LANES];
    logic               fo_reg  [DIV_STEPS+1][LANES];
    logic [NUM_W-1:0]   rem_next [DIV_STEPS][LANES];
    logic [MU_W-1:0]    q_next   [DIV_STEPS][LANES];

    logic [MU_W-1:0]    r_reg [GEXP_BITS+1][LANES];
    logic [7:0]         t_reg [GEXP_BITS+1][LANES];
    logic [MU_W-1:0]    r_next [GEXP_BITS][LANES];

    // width^2 registered; the user must move config only while idle, not enforced
    always_ff @(posedge clk)
    begin
        w2_reg <= DEN_W'(cfg.width) * DEN_W'(cfg.width);
    end

    // stage P1: triangle dividend or squared distance
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sq[l] = ad[l] * ad[l];
            if (cfg.shape_mode)
                n1_next[l] = NUM_W'(sq[l]);
            else if (AD_W'(cfg.width) > ad[l])
                n1_next[l] = NUM_W'(15'(cfg.width - ad[l][14:0])) << MU_FRAC;
            else
                n1_next[l] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P1])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                n1_reg[l] <= n1_next[l];
                z1_reg[l] <= (ad[l] == '0);
            end
        end
    end

    // stage P2: set up the divide, catch forced results
    always_ff @(posedge clk)
    begin
        if (en[ST_P2])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= cfg.shape_mode ? (n1_reg[l] << 3) : n1_reg[l];
                dv_reg[0][l]  <= cfg.shape_mode ? w2_reg : DEN_W'(cfg.width);
                q_reg[0][l]   <= '0;
                fc_reg[0][l]  <= (cfg.width == '0) ||
                                 (cfg.shape_mode &&
                                  ((n1_reg[l] << 3) >= (NUM_W'(w2_reg) << GEXP_BITS)));
                fo_reg[0][l]  <= cfg.shape_mode && (cfg.width == '0) && z1_reg[l];
            end
        end
    end

    // restoring divide, one quotient bit per stage
    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (DIV_W'(rem_reg[s][l]) >= (DIV_W'(dv_reg[s][l]) << (DIV_STEPS-1-s)))
                begin
                    rem_next[s][l] = rem_reg[s][l] -
                                     NUM_W'(DIV_W'(dv_reg[s][l]) << (DIV_STEPS-1-s));
                    q_next[s][l]   = q_reg[s][l] | (MU_W'(1) << (DIV_STEPS-1-s));
                end
                else
                begin
                    rem_next[s][l] = rem_reg[s][l];
                    q_next[s][l]   = q_reg[s][l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            if (en[ST_DIV+s])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s+1][l] <= rem_next[s][l];
                    dv_reg[s+1][l]  <= dv_reg[s][l];
                    q_reg[s+1][l]   <= q_next[s][l];
                    fc_reg[s+1][l]  <= fc_reg[s][l];
                    fo_reg[s+1][l]  <= fo_reg[s][l];
                end
            end
        end
    end

    // post: forced lanes 0 or 1, triangle the quotient, gaussian starts at one
    always_ff @(posedge clk)
    begin
        if (en[ST_POST])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (fc_reg[DIV_STEPS][l])
                    r_reg[0][l] <= fo_reg[DIV_STEPS][l] ? MU_ONE : '0;
                else
                    r_reg[0][l] <= cfg.shape_mode ? MU_ONE : q_reg[DIV_STEPS][l];
                t_reg[0][l] <= (cfg.shape_mode && !fc_reg[DIV_STEPS][l]) ?
                               q_reg[DIV_STEPS][l][7:0] : 8'd0;
            end
        end
    end

    // exponent chain: one rounded multiply per set bit
    always_comb
    begin
        for (int b = 0; b < GEXP_BITS; b++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (t_reg[b][l][b])
                    r_next[b][l] = MU_W'(((MU_W+16)'(r_reg[b][l]) * (MU_W+16)'(GEXP[b])
                                          + (MU_W+16)'(32768)) >> 16);
                else
                    r_next[b][l] = r_reg[b][l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < GEXP_BITS; b++)
        begin
            if (en[ST_GMUL+b])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    r_reg[b+1][l] <= r_next[b][l];
                    t_reg[b+1][l] <= t_reg[b][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            mu[l] = r_reg[GEXP_BITS][l];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fpd_defuzz.sv -----
// Rule inference and weighted-average defuzzification with a pipelined
// rounding divide and saturation. Depends on fpd_pkg; enables come from the top.
`default_nettype none

module fpd_defuzz
(
    input  logic                                          clk,
    input  logic [fpd_pkg::NSTG-1:0]                      en,
    input  fpd_pkg::cfg_t                                 cfg,
    input  logic [fpd_pkg::LANES-1:0][fpd_pkg::MU_W-1:0]  mu,
    output logic signed [fpd_pkg::OUT_W-1:0]              corr
);
    import fpd_pkg::*;

    logic [MU_W-1:0]          wmin_reg [SETS][SETS];
    logic [W_W-1:0]           wr_next  [SETS];
    logic [W_W-1:0]           wr_reg   [SETS];
    logic signed [P_W-1:0]    p_next   [SETS];
    logic signed [P_W-1:0]    p_reg    [SETS];
    logic [W_W-1:0]           den_next;
    logic [W_W-1:0]           den_reg;
    logic signed [NM_W-1:0]   num_next;
    logic signed [NM_W-1:0]   num_reg;
    logic [W_W-1:0]           den2_reg;
    logic signed [W_W:0]      wsg [SETS];
    logic signed [CTR_W-1:0]  val [SETS];
    logic [NM_W-1:0]          mag;

    logic [M_W-1:0]           qrem_reg  [QDIV_STEPS+1];
    logic [W_W-1:0]           qden_reg  [QDIV_STEPS+1];
    logic [QDIV_STEPS-1:0]    qq_reg    [QDIV_STEPS+1];
    logic                     qneg_reg  [QDIV_STEPS+1];
    logic                     qovr_reg  [QDIV_STEPS+1];
    logic                     qzero_reg [QDIV_STEPS+1];
    logic [M_W-1:0]           qrem_next [QDIV_STEPS];
    logic [QDIV_STEPS-1:0]    qq_next   [QDIV_STEPS];

    logic [OUT_W-1:0]         qm;
    logic signed [OUT_W-1:0]  corr_next;
    logic signed [OUT_W-1:0]  corr_reg;

    // min inference
    always_ff @(posedge clk)
    begin
        if (en[ST_MIN])
        begin
            for (int i = 0; i < SETS; i++)
                for (int j = 0; j < SETS; j++)
                    wmin_reg[i][j] <= (mu[i] < mu[SETS+j]) ? mu[i] : mu[SETS+j];
        end
    end

    // gather rule weights per output set
    always_comb
    begin
        for (int r = 0; r < SETS; r++)
        begin
            wr_next[r] = '0;
            for (int i = 0; i < SETS; i++)
                for (int j = 0; j < SETS; j++)
                    if (rule_out(i, j) == r)
                        wr_next[r] = wr_next[r] + W_W'(wmin_reg[i][j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_AGG])
        begin
            for (int r = 0; r < SETS; r++)
                wr_reg[r] <= wr_next[r];
        end
    end

    // weight times output value: set centre, or set index in gaussian mode
    always_comb
    begin
        den_next = '0;
        for (int r = 0; r < SETS; r++)
        begin
            wsg[r]   = signed'({1'b0, wr_reg[r]});
            val[r]   = cfg.shape_mode ? CTR_W'(r) : set_ctr(cfg, r);
            p_next[r] = wsg[r] * val[r];
            den_next = den_next + wr_reg[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            for (int r = 0; r < SETS; r++)
                p_reg[r] <= p_next[r];
            den_reg <= den_next;
        end
    end

    always_comb
    begin
        num_next = '0;
        for (int r = 0; r < SETS; r++)
            num_next = num_next + NM_W'(p_reg[r]);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            num_reg  <= num_next;
            den2_reg <= den_reg;
        end
    end

    // rounding: |num|*256 + den/2, quotient clipped at 2^23
    assign mag = num_reg[NM_W-1] ? NM_W'(-num_reg) : NM_W'(num_reg);

    always_ff @(posedge clk)
    begin
        if (en[ST_PRE])
        begin
            qrem_reg[0]  <= (M_W'(mag) << 8) + M_W'(den2_reg >> 1);
            qden_reg[0]  <= den2_reg;
            qq_reg[0]    <= '0;
            qneg_reg[0]  <= num_reg[NM_W-1];
            qovr_reg[0]  <= ((M_W'(mag) << 8) + M_W'(den2_reg >> 1)) >=
                            (M_W'(den2_reg) << QDIV_STEPS);
            qzero_reg[0] <= (den2_reg == '0);
        end
    end

    always_comb
    begin
        for (int s = 0; s < QDIV_STEPS; s++)
        begin
            if (qrem_reg[s] >= (M_W'(qden_reg[s]) << (QDIV_STEPS-1-s)))
            begin
                qrem_next[s] = qrem_reg[s] - (M_W'(qden_reg[s]) << (QDIV_STEPS-1-s));
                qq_next[s]   = qq_reg[s] | (QDIV_STEPS'(1) << (QDIV_STEPS-1-s));
            end
            else
            begin
                qrem_next[s] = qrem_reg[s];
                qq_next[s]   = qq_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QDIV_STEPS; s++)
        begin
            if (en[ST_QDIV+s])
            begin
                qrem_reg[s+1]  <= qrem_next[s];
                qden_reg[s+1]  <= qden_reg[s];
                qq_reg[s+1]    <= qq_next[s];
                qneg_reg[s+1]  <= qneg_reg[s];
                qovr_reg[s+1]  <= qovr_reg[s];
                qzero_reg[s+1] <= qzero_reg[s];
            end
        end
    end

    // sign and saturate
    always_comb
    begin
        if (qzero_reg[QDIV_STEPS])
            qm = '0;
        else if (qovr_reg[QDIV_STEPS])
            qm = OUT_OVER;
        else
            qm = OUT_W'(qq_reg[QDIV_STEPS]);
        if (qneg_reg[QDIV_STEPS])
            corr_next = signed'(-qm);
        else if (qm[OUT_W-1])
            corr_next = signed'(OUT_MAX);
        else
            corr_next = signed'(qm);
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
            corr_reg <= corr_next;
    end

    assign corr = corr_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fuzzy_pd_controller_core.sv -----
// Fuzzy PD controller, Mamdani min inference with weighted-average output.
// Throughput one request per cycle while the output is not stalled, set by a
// fully pipelined datapath (17-stage membership divide, 8-stage exponent
// chain, 23-stage output divide). Stalls collapse bubbles stage by stage.
// rst_n (async, active low) empties the pipeline and loads register defaults:
// centre 0, width 20, spacing 20, triangular shape.
`default_nettype none

module fuzzy_pd_controller_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [15:0]                            cfg_data,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  logic signed [15:0]                     error,
    input  logic signed [15:0]                     error_change,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [fpd_pkg::OUT_W-1:0]       correction,
    output logic                                   out_of_bounds
);
    import fpd_pkg::*;

    // configuration registers
    logic signed [15:0] centre_reg;
    logic [14:0]        width_reg;
    logic [14:0]        spacing_reg;
    logic               shape_mode_reg;
    cfg_t               cfg;

    // pipeline control: one valid bit per stage, enables ripple back from the output
    logic [NSTG-1:0]    v_reg;
    logic [NSTG-1:0]    v_next;
    logic [NSTG-1:0]    en;
    logic [NSTG-1:0]    oob_reg;

    // input stage datapath
    logic [LANES-1:0][AD_W-1:0] ad_next;
    logic [LANES-1:0][AD_W-1:0] ad_reg;
    logic [LANES-1:0][MU_W-1:0] mu;
    logic signed [CTR_W-1:0]    x;
    logic signed [CTR_W-1:0]    d;
    logic signed [CTR_W-1:0]    lo;
    logic signed [CTR_W-1:0]    hi;
    logic signed [CTR_W-1:0]    ex;
    logic signed [CTR_W-1:0]    dx;
    logic                       oob_next;
    logic signed [OUT_W-1:0]    corr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg     <= '0;
            width_reg      <= 15'd20;
            spacing_reg    <= 15'd20;
            shape_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTRE:  centre_reg     <= signed'(cfg_data);
                REG_WIDTH:   width_reg      <= cfg_data[14:0];
                REG_SPACING: spacing_reg    <= cfg_data[14:0];
                REG_SHAPE:   shape_mode_reg <= cfg_data[0];
            endcase
        end
    end

    assign cfg.centre     = centre_reg;
    assign cfg.width      = width_reg;
    assign cfg.spacing    = spacing_reg;
    assign cfg.shape_mode = shape_mode_reg;

    // A stage may load when it is empty or everything from it onward is
    // moving; equivalent to a ripple of (!v | en_next) without the long chain.
    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
            en[k] = result_ready || !(&(v_reg | ~({NSTG{1'b1}} << k)));
    end

    always_comb
    begin
        v_next[0] = en[0] ? sample_valid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign sample_ready = en[ST_IN];
    assign result_valid = v_reg[NSTG-1];

    // input stage: distance to every set centre, and the triangular bound check
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            x = (l < SETS) ? CTR_W'(error) : CTR_W'(error_change);
            d = x - set_ctr(cfg, l % SETS);
            ad_next[l] = d[CTR_W-1] ? AD_W'(-d) : AD_W'(d);
        end
        lo = set_ctr(cfg, 0) + signed'(CTR_W'(width_reg));
        hi = set_ctr(cfg, SETS - 1) - signed'(CTR_W'(width_reg));
        ex = CTR_W'(error);
        dx = CTR_W'(error_change);
        oob_next = !shape_mode_reg &&
                   ((ex >= hi) || (ex <= lo) || (dx >= hi) || (dx <= lo));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
            ad_reg <= ad_next;
    end

    // rejection flag rides alongside the data
    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
            oob_reg[0] <= oob_next;
        for (int k = 1; k < NSTG; k++)
            if (en[k])
                oob_reg[k] <= oob_reg[k-1];
    end

    fpd_member u_member
    (
        .clk (clk),
        .en  (en),
        .cfg (cfg),
        .ad  (ad_reg),
        .mu  (mu)
    );

    fpd_defuzz u_defuzz
    (
        .clk  (clk),
        .en   (en),
        .cfg  (cfg),
        .mu   (mu),
        .corr (corr)
    );

    // a rejected request reports zero
    assign correction    = oob_reg[NSTG-1] ? '0 : corr;
    assign out_of_bounds = oob_reg[NSTG-1];

    // occupancy changes only by requests taken in and results handed out
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(v_reg) == $countones($past(v_reg))
                 + int'($past(sample_valid && sample_ready))
                 - int'($past(result_valid && result_ready)))
        else $error("pipeline occupancy mismatch");

    // input is refused only with every stage full and the output stalled
    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> ((&v_reg) && !result_ready))
        else $error("input refused with room in the pipeline");

endmodule

`default_nettype wire
